// File: src/bsc_pkg.sv
package bsc_pkg;

    // Pipeline depth, one valid bit per stage
    localparam int NUM_STAGES = 10;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int COEFF_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS        = 3'd0,
        CFG_OFFSET      = 3'd1,
        CFG_SENS_TEMP   = 3'd2,
        CFG_OFFSET_TEMP = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_SLOPE  = 3'd5
    } bsc_cfg_idx_t;

    // Word fields
    localparam int RAW_W  = 24;
    localparam int TEMP_W = 15;
    localparam int PRES_W = 17;

    // Compensated sensitivity and the wide product
    localparam int SENS_W = 42;
    localparam int PROD_W = 67;

    // Compensation constants (centidegrees, centi-mbar)
    localparam int TEMP_BASE  = 2000;
    localparam int COLD_LIMIT = -1500;
    localparam int OFF2_MUL   = 61;
    localparam int OFF3_MUL   = 15;
    localparam int SENS3_MUL  = 8;
    localparam int TEMP_LOW   = -4000;
    localparam int TEMP_HIGH  = 8500;
    localparam int PRES_LOW   = 1000;
    localparam int PRES_HIGH  = 120000;

    // Load enables of the two wide multiplier stages
    typedef struct packed {
        logic part;
        logic sum;
    } bsc_mul_en_t;

endpackage

// File: src/bsc_wide_mul.sv
module bsc_wide_mul
    import bsc_pkg::*;
(
    input  logic                      clk,
    input  bsc_mul_en_t               en,
    input  logic [RAW_W-1:0]          d1,
    input  logic signed [SENS_W-1:0]  sens,
    output logic signed [PROD_W-1:0]  prod
);

    localparam int LO_W = SENS_W / 2;
    localparam int HI_W = SENS_W - LO_W;

    logic [RAW_W+LO_W-1:0]          lo_next;
    logic [RAW_W+LO_W-1:0]          lo_reg;
    logic signed [RAW_W+HI_W:0]     hi_next;
    logic signed [RAW_W+HI_W:0]     hi_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_reg;

    // Partial products: unsigned low half, signed high half
    always_comb
    begin
        lo_next = d1 * sens[LO_W-1:0];
        hi_next = $signed({1'b0, d1}) * $signed(sens[SENS_W-1:LO_W]);
    end

    // Recombine
    always_comb
    begin
        prod_next = ($signed(PROD_W'(hi_reg)) <<< LO_W)
                  + $signed(PROD_W'({1'b0, lo_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en.part)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (en.sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: src/baro_sensor_compensation.sv
// Barometric sensor compensation, second-order temperature correction.
// Throughput: one word per cycle while out_stall is low; ten register stages,
// each with its own valid bit, advance independently so bubbles close up under
// output stall.
// Reset (rst_n low, asynchronous) clears all valid bits and all six
// coefficient registers to zero; the block accepts words right after reset.
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEFF_W-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [RAW_W-1:0]         pressure_raw,
    input  logic [RAW_W-1:0]         temperature_raw,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic [PRES_W-1:0]        pressure_centi_mbar
);

    localparam logic signed [41:0] RND23 = 42'sd8388607;
    localparam logic signed [41:0] RND6  = 42'sd63;
    localparam logic signed [41:0] RND7  = 42'sd127;
    localparam logic signed [PROD_W-1:0] RND21 = PROD_W'(2097151);
    localparam logic signed [47:0] RND15 = 48'sd32767;

    // Coefficient registers
    logic [COEFF_W-1:0] sens_coeff_reg;
    logic [COEFF_W-1:0] offset_coeff_reg;
    logic [COEFF_W-1:0] sens_temp_coeff_reg;
    logic [COEFF_W-1:0] offset_temp_coeff_reg;
    logic [COEFF_W-1:0] ref_temp_coeff_reg;
    logic [COEFF_W-1:0] temp_slope_coeff_reg;

    // Pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_rdy;
    bsc_mul_en_t           mul_en;

    // Stage 0: temperature difference
    logic signed [24:0]        s0_dt_next;
    logic signed [24:0]        s0_dt_reg;
    logic [RAW_W-1:0]          s0_d1_reg;

    // Stage 1: first-order products
    logic signed [41:0]        s1_ptemp_next;
    logic signed [41:0]        s1_poff_next;
    logic signed [41:0]        s1_psens_next;
    logic signed [49:0]        s1_dtsq_full;
    logic [47:0]               s1_dtsq_next;
    logic signed [41:0]        s1_ptemp_reg;
    logic signed [41:0]        s1_poff_reg;
    logic signed [41:0]        s1_psens_reg;
    logic [47:0]               s1_dtsq_reg;
    logic [RAW_W-1:0]          s1_d1_reg;

    // Stage 2: TEMP, OFF, SENS, T2
    logic signed [41:0]        s2_ptemp_adj;
    logic signed [41:0]        s2_poff_adj;
    logic signed [41:0]        s2_psens_adj;
    logic signed [18:0]        s2_temp_next;
    logic signed [35:0]        s2_off_next;
    logic signed [34:0]        s2_sens_next;
    logic signed [18:0]        s2_temp_reg;
    logic signed [35:0]        s2_off_reg;
    logic signed [34:0]        s2_sens_reg;
    logic [16:0]               s2_t2_reg;
    logic [RAW_W-1:0]          s2_d1_reg;

    // Stage 3: squares of the temperature deltas
    logic signed [19:0]        s3_dw;
    logic signed [19:0]        s3_dc;
    logic signed [39:0]        s3_dwsq_full;
    logic signed [39:0]        s3_dcsq_full;
    logic                      s3_warm_next;
    logic                      s3_cold_next;
    logic signed [19:0]        s3_temp_next;
    logic [35:0]               s3_dwsq_reg;
    logic [35:0]               s3_dcsq_reg;
    logic                      s3_warm_reg;
    logic                      s3_cold_reg;
    logic signed [19:0]        s3_temp_reg;
    logic signed [35:0]        s3_off_reg;
    logic signed [34:0]        s3_sens_reg;
    logic [RAW_W-1:0]          s3_d1_reg;

    // Stage 4: second-order offset and sensitivity
    logic [43:0]               s4_off2;
    logic [39:0]               s4_sens2;
    logic signed [45:0]        s4_off_next;
    logic signed [SENS_W-1:0]  s4_sens_next;
    logic signed [TEMP_W-1:0]  s4_temp_next;
    logic signed [45:0]        s4_off_reg;
    logic signed [SENS_W-1:0]  s4_sens_reg;
    logic signed [TEMP_W-1:0]  s4_temp_reg;
    logic [RAW_W-1:0]          s4_d1_reg;

    // Stages 5 and 6: wide product D1 * SENS
    logic signed [PROD_W-1:0]  s6_prod;
    logic signed [45:0]        s5_off_reg;
    logic signed [TEMP_W-1:0]  s5_temp_reg;
    logic signed [45:0]        s6_off_reg;
    logic signed [TEMP_W-1:0]  s6_temp_reg;

    // Stage 7: product / 2^21
    logic signed [PROD_W-1:0]  s7_prod_adj;
    logic signed [45:0]        s7_q_reg;
    logic signed [45:0]        s7_off_reg;
    logic signed [TEMP_W-1:0]  s7_temp_reg;

    // Stage 8: subtract offset
    logic signed [47:0]        s8_x_next;
    logic signed [47:0]        s8_x_reg;
    logic signed [TEMP_W-1:0]  s8_temp_reg;

    // Stage 9: / 2^15 and clamp
    logic signed [47:0]        s9_x_adj;
    logic signed [32:0]        s9_p;
    logic [PRES_W-1:0]         s9_pres_next;
    logic [PRES_W-1:0]         s9_pres_reg;
    logic signed [TEMP_W-1:0]  s9_temp_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_coeff_reg        <= '0;
            offset_coeff_reg      <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_coeff_reg    <= '0;
            temp_slope_coeff_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SENS:        sens_coeff_reg        <= cfg_data;
                CFG_OFFSET:      offset_coeff_reg      <= cfg_data;
                CFG_SENS_TEMP:   sens_temp_coeff_reg   <= cfg_data;
                CFG_OFFSET_TEMP: offset_temp_coeff_reg <= cfg_data;
                CFG_REF_TEMP:    ref_temp_coeff_reg    <= cfg_data;
                CFG_TEMP_SLOPE:  temp_slope_coeff_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Per-stage ready: a stage loads when empty or when the next one moves
    always_comb
    begin
        stage_rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    assign in_stall  = !stage_rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0
    always_comb
    begin
        s0_dt_next = $signed({1'b0, temperature_raw})
                   - $signed({1'b0, ref_temp_coeff_reg, 8'd0});
    end

    // Stage 1
    always_comb
    begin
        s1_ptemp_next = s0_dt_reg * $signed({1'b0, temp_slope_coeff_reg});
        s1_poff_next  = s0_dt_reg * $signed({1'b0, offset_temp_coeff_reg});
        s1_psens_next = s0_dt_reg * $signed({1'b0, sens_temp_coeff_reg});
        s1_dtsq_full  = s0_dt_reg * s0_dt_reg;
        s1_dtsq_next  = s1_dtsq_full[47:0];
    end

    // Stage 2: divisions truncate toward zero
    always_comb
    begin
        s2_ptemp_adj = s1_ptemp_reg + (s1_ptemp_reg[41] ? RND23 : 42'sd0);
        s2_poff_adj  = s1_poff_reg + (s1_poff_reg[41] ? RND6 : 42'sd0);
        s2_psens_adj = s1_psens_reg + (s1_psens_reg[41] ? RND7 : 42'sd0);
        s2_temp_next = $signed(s2_ptemp_adj[41:23]) + 19'(TEMP_BASE);
        s2_off_next  = $signed({3'b0, offset_coeff_reg, 17'd0})
                     + $signed(s2_poff_adj[41:6]);
        s2_sens_next = $signed({3'b0, sens_coeff_reg, 16'd0})
                     + $signed(s2_psens_adj[41:7]);
    end

    // Stage 3: squares, range flags, T2 applied
    always_comb
    begin
        s3_dw        = $signed({s2_temp_reg[18], s2_temp_reg}) - 20'(TEMP_BASE);
        s3_dc        = $signed({s2_temp_reg[18], s2_temp_reg}) - 20'(COLD_LIMIT);
        s3_dwsq_full = s3_dw * s3_dw;
        s3_dcsq_full = s3_dc * s3_dc;
        s3_warm_next = (s2_temp_reg < TEMP_BASE);
        s3_cold_next = (s2_temp_reg < COLD_LIMIT);
        s3_temp_next = $signed({s2_temp_reg[18], s2_temp_reg})
                     - (s3_warm_next ? $signed({3'b0, s2_t2_reg}) : 20'sd0);
    end

    // Stage 4: OFF2, SENS2, temperature clamp
    always_comb
    begin
        s4_off2  = '0;
        s4_sens2 = '0;
        if (s3_warm_reg)
        begin
            s4_off2  = (44'(s3_dwsq_reg) * 44'(OFF2_MUL)) >> 4;
            s4_sens2 = 40'(s3_dwsq_reg) << 1;
            if (s3_cold_reg)
            begin
                s4_off2  = s4_off2 + 44'(s3_dcsq_reg) * 44'(OFF3_MUL);
                s4_sens2 = s4_sens2 + 40'(s3_dcsq_reg) * 40'(SENS3_MUL);
            end
        end
        s4_off_next  = 46'(s3_off_reg) - $signed({2'b0, s4_off2});
        s4_sens_next = SENS_W'(s3_sens_reg) - $signed({2'b0, s4_sens2});
        if (s3_temp_reg < TEMP_LOW)
        begin
            s4_temp_next = TEMP_W'(TEMP_LOW);
        end
        else if (s3_temp_reg > TEMP_HIGH)
        begin
            s4_temp_next = TEMP_W'(TEMP_HIGH);
        end
        else
        begin
            s4_temp_next = s3_temp_reg[TEMP_W-1:0];
        end
    end

    // Stages 5 and 6: wide multiplier
    assign mul_en.part = stage_rdy[5];
    assign mul_en.sum  = stage_rdy[6];

    bsc_wide_mul u_wide_mul (
        .clk  (clk),
        .en   (mul_en),
        .d1   (s4_d1_reg),
        .sens (s4_sens_reg),
        .prod (s6_prod)
    );

    // Stage 7
    always_comb
    begin
        s7_prod_adj = s6_prod + (s6_prod[PROD_W-1] ? RND21 : PROD_W'(0));
    end

    // Stage 8
    always_comb
    begin
        s8_x_next = 48'(s7_q_reg) - 48'(s7_off_reg);
    end

    // Stage 9: pressure scaling and clamp
    always_comb
    begin
        s9_x_adj = s8_x_reg + (s8_x_reg[47] ? RND15 : 48'sd0);
        s9_p     = s9_x_adj[47:15];
        if (s9_p < PRES_LOW)
        begin
            s9_pres_next = PRES_W'(PRES_LOW);
        end
        else if (s9_p > PRES_HIGH)
        begin
            s9_pres_next = PRES_W'(PRES_HIGH);
        end
        else
        begin
            s9_pres_next = s9_p[PRES_W-1:0];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            s0_dt_reg <= s0_dt_next;
            s0_d1_reg <= pressure_raw;
        end
        if (stage_rdy[1])
        begin
            s1_ptemp_reg <= s1_ptemp_next;
            s1_poff_reg  <= s1_poff_next;
            s1_psens_reg <= s1_psens_next;
            s1_dtsq_reg  <= s1_dtsq_next;
            s1_d1_reg    <= s0_d1_reg;
        end
        if (stage_rdy[2])
        begin
            s2_temp_reg <= s2_temp_next;
            s2_off_reg  <= s2_off_next;
            s2_sens_reg <= s2_sens_next;
            s2_t2_reg   <= s1_dtsq_reg[47:31];
            s2_d1_reg   <= s1_d1_reg;
        end
        if (stage_rdy[3])
        begin
            s3_dwsq_reg <= s3_dwsq_full[35:0];
            s3_dcsq_reg <= s3_dcsq_full[35:0];
            s3_warm_reg <= s3_warm_next;
            s3_cold_reg <= s3_cold_next;
            s3_temp_reg <= s3_temp_next;
            s3_off_reg  <= s2_off_reg;
            s3_sens_reg <= s2_sens_reg;
            s3_d1_reg   <= s2_d1_reg;
        end
        if (stage_rdy[4])
        begin
            s4_off_reg  <= s4_off_next;
            s4_sens_reg <= s4_sens_next;
            s4_temp_reg <= s4_temp_next;
            s4_d1_reg   <= s3_d1_reg;
        end
        if (stage_rdy[5])
        begin
            s5_off_reg  <= s4_off_reg;
            s5_temp_reg <= s4_temp_reg;
        end
        if (stage_rdy[6])
        begin
            s6_off_reg  <= s5_off_reg;
            s6_temp_reg <= s5_temp_reg;
        end
        if (stage_rdy[7])
        begin
            s7_q_reg    <= s7_prod_adj[PROD_W-1:21];
            s7_off_reg  <= s6_off_reg;
            s7_temp_reg <= s6_temp_reg;
        end
        if (stage_rdy[8])
        begin
            s8_x_reg    <= s8_x_next;
            s8_temp_reg <= s7_temp_reg;
        end
        if (stage_rdy[9])
        begin
            s9_pres_reg <= s9_pres_next;
            s9_temp_reg <= s8_temp_reg;
        end
    end

    assign temperature_centi   = s9_temp_reg;
    assign pressure_centi_mbar = s9_pres_reg;

endmodule

// File: tb/sv/tb_baro_sensor_compensation.sv
module tb_baro_sensor_compensation;
    timeunit 1ns;
    timeprecision 1ps;
    import bsc_pkg::*;

    // Fixed-point scale factors and thresholds of the compensation
    localparam longint POW4  = 64'sd16;
    localparam longint POW6  = 64'sd64;
    localparam longint POW7  = 64'sd128;
    localparam longint POW15 = 64'sd32768;
    localparam longint POW16 = 64'sd65536;
    localparam longint POW17 = 64'sd131072;
    localparam longint POW21 = 64'sd2097152;
    localparam longint POW23 = 64'sd8388608;
    localparam longint POW31 = 64'sd2147483648;
    localparam longint REF_SCALE = 64'sd256;

    localparam longint T_BASE  = 64'sd2000;
    localparam longint T_COLD  = -64'sd1500;
    localparam longint OFF2_K  = 64'sd61;
    localparam longint OFF3_K  = 64'sd15;
    localparam longint SENS2_K = 64'sd2;
    localparam longint SENS3_K = 64'sd8;
    localparam longint T_MIN   = -64'sd4000;
    localparam longint T_MAX   = 64'sd8500;
    localparam longint P_MIN   = 64'sd1000;
    localparam longint P_MAX   = 64'sd120000;
    localparam longint RAW_MAX = 64'sd16777215;

    // Unused register slots, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES  = NUM_STAGES + 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int NUM_SETS      = 6;
    localparam int WORDS_PER_SET = 185;
    localparam int HOLD_CYCLES   = 300;
    localparam int BURST_WORDS   = 120;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [PRES_W-1:0]        pres;
    } reading_t;

    typedef struct packed {
        logic                     is_write;
        logic [CFG_IDX_W-1:0]     idx;
        logic [COEFF_W-1:0]       data;
        logic [RAW_W-1:0]         d1;
        logic [RAW_W-1:0]         d2;
        logic                     typed;
        logic signed [TEMP_W-1:0] t;
        logic [PRES_W-1:0]        p;
    } step_t;

    typedef enum {SET_TYPICAL, SET_RANDOM, SET_MAX, SET_ZERO} coeff_set_t;

    localparam logic [COEFF_W-1:0] TYP_COEFF [6] =
        '{46372, 43981, 29059, 27842, 31553, 28165};
    localparam coeff_set_t SET_PLAN [NUM_SETS] =
        '{SET_TYPICAL, SET_RANDOM, SET_MAX, SET_TYPICAL, SET_RANDOM, SET_ZERO};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [COEFF_W-1:0]       cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [RAW_W-1:0]         pressure_raw = '0;
    logic [RAW_W-1:0]         temperature_raw = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [PRES_W-1:0]        pressure_centi_mbar;

    // Shadow copy of the coefficient registers
    logic [COEFF_W-1:0] coeff [6] = '{default: '0};

    reading_t pending_q [$];
    step_t    plan_q [$];

    // Word currently on the input, with its hand-written expectation if any
    logic                     cur_typed = 1'b0;
    logic signed [TEMP_W-1:0] cur_t = '0;
    logic [PRES_W-1:0]        cur_p = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cnt = 0;
    int err_cnt = 0;
    int words_in = 0;
    int results_checked = 0;
    int cold_cnt = 0;
    int clamp_cnt = 0;
    int cycle_cnt = 0;

    baro_sensor_compensation u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .pressure_raw        (pressure_raw),
        .temperature_raw     (temperature_raw),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .temperature_centi   (temperature_centi),
        .pressure_centi_mbar (pressure_centi_mbar)
    );

    always #1 clk = ~clk;

    // Compensated temperature and pressure for one pair of raw conversions
    function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint d1, d2, dt, t, off, sens, t2, off2, sens2, dw, dc, p;
        longint c_sens, c_off, c_senst, c_offt, c_ref, c_slope;
        reading_t r;
        d1 = d1_raw;
        d2 = d2_raw;
        c_sens  = coeff[CFG_SENS];
        c_off   = coeff[CFG_OFFSET];
        c_senst = coeff[CFG_SENS_TEMP];
        c_offt  = coeff[CFG_OFFSET_TEMP];
        c_ref   = coeff[CFG_REF_TEMP];
        c_slope = coeff[CFG_TEMP_SLOPE];

        // first order
        dt   = d2 - c_ref * REF_SCALE;
        t    = T_BASE + (dt * c_slope) / POW23;
        off  = c_off * POW17 + (c_offt * dt) / POW6;
        sens = c_sens * POW16 + (c_senst * dt) / POW7;

        // second order below 20 C, extra terms below -15 C
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (t < T_BASE)
        begin
            dw    = t - T_BASE;
            t2    = (dt * dt) / POW31;
            off2  = (OFF2_K * dw * dw) / POW4;
            sens2 = SENS2_K * dw * dw;
            if (t < T_COLD)
            begin
                dc    = t - T_COLD;
                off2  = off2 + OFF3_K * dc * dc;
                sens2 = sens2 + SENS3_K * dc * dc;
            end
        end
        t    = t - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = ((d1 * sens) / POW21 - off) / POW15;

        if (t < T_MIN) t = T_MIN;
        else if (t > T_MAX) t = T_MAX;
        if (p < P_MIN) p = P_MIN;
        else if (p > P_MAX) p = P_MAX;
        r.temp = t[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    // Scoreboard: track register writes, predict accepted words, check results
    always @(posedge clk)
    begin : scoreboard
        reading_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready && cfg_index <= CFG_TEMP_SLOPE)
                coeff[cfg_index] = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (cur_typed)
                begin
                    want.temp = cur_t;
                    want.pres = cur_p;
                end
                else
                begin
                    want = compensate(pressure_raw, temperature_raw);
                end
                pending_q.push_back(want);
                words_in++;
                if (want.temp < T_COLD) cold_cnt++;
                if (want.temp == T_MIN || want.temp == T_MAX ||
                    want.pres == P_MIN || want.pres == P_MAX) clamp_cnt++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: unexpected word temp=%0d pres=%0d", $time,
                             temperature_centi, pressure_centi_mbar);
                    err_cnt++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    results_checked++;
                    if (temperature_centi !== want.temp)
                    begin
                        $display("%0t: temperature_centi expected %0d, got %0d", $time,
                                 want.temp, temperature_centi);
                        err_cnt++;
                    end
                    if (pressure_centi_mbar !== want.pres)
                    begin
                        $display("%0t: pressure_centi_mbar expected %0d, got %0d", $time,
                                 want.pres, pressure_centi_mbar);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: long hold-off on request, otherwise random stall
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt = hold_cnt - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [COEFF_W-1:0] val);
        step_t s;
        s = '0;
        s.is_write = 1'b1;
        s.idx = idx;
        s.data = val;
        plan_q.push_back(s);
    endfunction

    function automatic void add_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                                     input logic typed = 1'b0,
                                     input logic signed [TEMP_W-1:0] t = '0,
                                     input logic [PRES_W-1:0] p = '0);
        step_t s;
        s = '0;
        s.d1 = d1;
        s.d2 = d2;
        s.typed = typed;
        s.t = t;
        s.p = p;
        plan_q.push_back(s);
    endfunction

    function automatic void add_coeff_set(input logic [COEFF_W-1:0] c_sens, c_off, c_senst,
                                          input logic [COEFF_W-1:0] c_offt, c_ref, c_slope);
        add_write(CFG_SENS, c_sens);
        add_write(CFG_OFFSET, c_off);
        add_write(CFG_SENS_TEMP, c_senst);
        add_write(CFG_OFFSET_TEMP, c_offt);
        add_write(CFG_REF_TEMP, c_ref);
        add_write(CFG_TEMP_SLOPE, c_slope);
    endfunction

    // Drop valid and let every outstanding word drain out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                             input logic typed, input logic signed [TEMP_W-1:0] t,
                             input logic [PRES_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        pressure_raw    <= d1;
        temperature_raw <= d2;
        cur_typed = typed;
        cur_t = t;
        cur_p = p;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load_coeff_set(input coeff_set_t kind);
        logic [COEFF_W-1:0] nc [6];
        for (int i = 0; i < 6; i++)
        begin
            case (kind)
                SET_TYPICAL: nc[i] = TYP_COEFF[i] + COEFF_W'($urandom_range(4000)) - 16'd2000;
                SET_RANDOM:  nc[i] = COEFF_W'($urandom());
                SET_MAX:     nc[i] = '1;
                default:     nc[i] = '0;
            endcase
        end
        wait_idle();
        write_reg(CFG_SENS, nc[CFG_SENS]);
        write_reg(CFG_OFFSET, nc[CFG_OFFSET]);
        write_reg(CFG_SENS_TEMP, nc[CFG_SENS_TEMP]);
        write_reg(CFG_OFFSET_TEMP, nc[CFG_OFFSET_TEMP]);
        write_reg(CFG_REF_TEMP, nc[CFG_REF_TEMP]);
        write_reg(CFG_TEMP_SLOPE, nc[CFG_TEMP_SLOPE]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly readings that land between -60 C and +100 C before clamping,
    // the rest anywhere in the 24-bit range
    task automatic gen_word(output logic [RAW_W-1:0] d1, output logic [RAW_W-1:0] d2);
        longint target, dtv, d2v, slope, refv;
        slope = coeff[CFG_TEMP_SLOPE];
        refv  = coeff[CFG_REF_TEMP];
        if ($urandom_range(99) < 25 || slope == 0)
        begin
            d2 = RAW_W'($urandom());
        end
        else
        begin
            target = longint'($urandom_range(16000)) - 8000;
            dtv = (target * POW23) / slope;
            d2v = refv * REF_SCALE + dtv;
            if (d2v < 0) d2v = 0;
            else if (d2v > RAW_MAX) d2v = RAW_MAX;
            d2 = d2v[RAW_W-1:0];
        end
        if ($urandom_range(99) < 35)
            d1 = RAW_W'($urandom());
        else
            d1 = RAW_W'($urandom_range(9000000, 3000000));
    endtask

    initial
    begin : stimulus
        step_t s;
        logic writing;
        logic [RAW_W-1:0] d1, d2;

        // Directed table. Coefficients at reset are zero: 20.00 C, pressure at floor.
        add_word(24'h000000, 24'h000000, 1'b1, 15'sd2000, 17'd1000);
        add_word(24'hFFFFFF, 24'hFFFFFF, 1'b1, 15'sd2000, 17'd1000);
        // writes to the unused slots change nothing
        add_write(CFG_SPARE_LO, 16'hFFFF);
        add_write(CFG_SPARE_HI, 16'hFFFF);
        add_word(24'hABCDEF, 24'h123456, 1'b1, 15'sd2000, 17'd1000);
        // full sensitivity alone drives pressure into the ceiling
        add_write(CFG_SENS, 16'hFFFF);
        add_word(24'hFFFFFF, 24'h5A5A5A, 1'b1, 15'sd2000, 17'd120000);
        // typical sensor: nominal point, around the 20 C threshold, cold, around the -15 C threshold, clamps
        add_coeff_set(46372, 43981, 29059, 27842, 31553, 28165);
        add_word(24'd6465444, 24'd8077636);
        add_word(24'd6465444, 24'd8077568);
        add_word(24'd6465444, 24'd8077567);
        add_word(24'd6465444, 24'd8077270);
        add_word(24'd6465444, 24'd6886268);
        add_word(24'd6465444, 24'd7035668);
        add_word(24'd6465444, 24'd7035168);
        add_word(24'd6465444, 24'd7034668);
        add_word(24'hFFFFFF, 24'd0);
        add_word(24'd0, 24'hFFFFFF);
        add_word(24'hFFFFFF, 24'd8077636);
        add_word(24'd0, 24'd8077636);
        // every coefficient at its maximum
        add_coeff_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_word(24'h000000, 24'h000000);
        add_word(24'hFFFFFF, 24'hFFFFFF);
        add_word(24'hFFFFFF, 24'h000000);
        add_word(24'h000000, 24'hFFFFFF);
        // back to zero
        add_coeff_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_word(24'hFFFFFF, 24'h000000, 1'b1, 15'sd2000, 17'd1000);

        // reset
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        writing = 1'b0;
        foreach (plan_q[i])
        begin
            s = plan_q[i];
            if (s.is_write)
            begin
                if (!writing)
                begin
                    wait_idle();
                    writing = 1'b1;
                end
                write_reg(s.idx, s.data);
            end
            else
            begin
                if (writing)
                begin
                    @(negedge clk);
                    cfg_valid <= 1'b0;
                    writing = 1'b0;
                end
                send_word(s.d1, s.d2, s.typed, s.t, s.p);
            end
        end

        // random part: sender light/receiver heavy, then swapped, then no idling
        for (int set = 0; set < NUM_SETS; set++)
        begin
            if (set < 2)
            begin
                send_idle_pct = 16;
                recv_stall_pct = 60;
            end
            else if (set < 4)
            begin
                send_idle_pct = 60;
                recv_stall_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            load_coeff_set(SET_PLAN[set]);
            // first set: long output hold while input keeps streaming
            if (set == 0)
            begin
                hold_cnt = HOLD_CYCLES;
                send_idle_pct = 0;
            end
            for (int k = 0; k < WORDS_PER_SET; k++)
            begin
                if (set == 0 && k == BURST_WORDS) send_idle_pct = 16;
                if (set == 3 && k == WORDS_PER_SET / 2) wait_idle();
                gen_word(d1, d2);
                send_word(d1, d2, 1'b0, '0, '0);
            end
        end

        wait_idle();
        $display("Checked %0d results for %0d words over %0d coefficient sets",
                 results_checked, words_in, NUM_SETS);
        $display("plus the table; %0d results below -15 C, %0d at a saturation limit.",
                 cold_cnt, clamp_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
